[rtl/core/cds_pkg.sv]
package cds_pkg;

    // Default sizes of the stored year and of the step counter.
    localparam int unsigned DEF_YEAR_BITS  = 16;
    localparam int unsigned DEF_COUNT_BITS = 16;

    // Fixed widths of the port fields.
    localparam int unsigned PORT_YEAR_W  = 16;
    localparam int unsigned MONTH_W      = 4;
    localparam int unsigned DAY_W        = 5;

    // The leap rule repeats every 400 years; the year is tracked modulo 400.
    localparam int unsigned MOD_BASE = 400;
    localparam int unsigned MOD_W    = 9;

    // Date after reset.
    localparam int unsigned RESET_YEAR = 2000;

    // Operation codes.
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_FWD  = 2'd1;
    localparam logic [1:0] MODE_BWD  = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    // Month numbers.
    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MON_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MON_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    // Month lengths.
    localparam logic [DAY_W-1:0] LEN_LONG  = 5'd31;
    localparam logic [DAY_W-1:0] LEN_SHORT = 5'd30;
    localparam logic [DAY_W-1:0] LEN_LEAP  = 5'd29;
    localparam logic [DAY_W-1:0] LEN_FEB   = 5'd28;
    localparam logic [DAY_W-1:0] LEN_NONE  = 5'd0;
    localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;

    typedef struct packed {
        logic [1:0]             mode;
        logic [15:0]            count;
        logic [PORT_YEAR_W-1:0] load_year;
        logic [MONTH_W-1:0]     load_month;
        logic [DAY_W-1:0]       load_day;
    } t_in_word;

    typedef struct packed {
        logic [PORT_YEAR_W-1:0] cur_year;
        logic [MONTH_W-1:0]     cur_month;
        logic [DAY_W-1:0]       cur_day;
        logic                   is_leap;
        logic                   is_valid;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_STEP,
        ST_DONE
    } t_state;

    // Leap year from the year modulo 400: divisible by 4, but not a
    // century unless it is a multiple of 400 (residue zero).
    function automatic logic leap_of_mod(input logic [MOD_W-1:0] m);
        return (m[1:0] == 2'd0) && (m != 9'd100) && (m != 9'd200) && (m != 9'd300);
    endfunction

    // Days in a month; months outside 1 to 12 have length zero.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC:
                len = LEN_LONG;
            MON_APR, MON_JUN, MON_SEP, MON_NOV:
                len = LEN_SHORT;
            MON_FEB:
                len = leap ? LEN_LEAP : LEN_FEB;
            default:
                len = LEN_NONE;
        endcase
        return len;
    endfunction

endpackage

[rtl/core/calendar_date_stepper_unit.sv]
// Gregorian date counter. The unit holds a date (YEAR_BITS-bit year, month,
// day), reset to 1 Jan 2000. Each input word either loads a date as given or
// moves it count days forward or backward, and each returns one output word
// with the date, the leap flag and a validity flag. One word is worked on at
// a time and o_in_ready stays low until its result is in the output
// register. A step walks one calendar day per cycle through the day step
// logic. A load waits for the year modulo 400 reduction (a reciprocal
// multiply, then a multiply and subtract) that feeds the leap rule. A zero
// count or the unused mode leaves the date as it is and goes straight to the
// output stage. A result word waits there while an earlier result word
// still waits in the output register.
module calendar_date_stepper_unit #(
    parameter int unsigned YEAR_BITS  = cds_pkg::DEF_YEAR_BITS,
    parameter int unsigned COUNT_BITS = cds_pkg::DEF_COUNT_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cds_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cds_pkg::t_out_word o_out_data
);

    cds_pkg::t_state              r_state, n_state;
    logic [YEAR_BITS-1:0]         r_year, n_year;
    logic [cds_pkg::MONTH_W-1:0]  r_month, n_month;
    logic [cds_pkg::DAY_W-1:0]    r_day, n_day;
    logic [cds_pkg::MOD_W-1:0]    r_mod, n_mod;
    logic [COUNT_BITS-1:0]        r_remain, n_remain;
    logic                         r_back, n_back;
    logic                         r_out_valid, n_out_valid;
    cds_pkg::t_out_word           r_out_data, n_out_data;

    logic                         in_fire;
    logic [COUNT_BITS-1:0]        in_count;
    logic [YEAR_BITS-1:0]         load_year;
    logic                         mod_start;
    logic                         mod_done;
    logic [cds_pkg::MOD_W-1:0]    mod_rem;
    logic [YEAR_BITS-1:0]         st_year;
    logic [cds_pkg::MONTH_W-1:0]  st_month;
    logic [cds_pkg::DAY_W-1:0]    st_day;
    logic [cds_pkg::MOD_W-1:0]    st_mod;
    logic                         cur_leap;
    logic [cds_pkg::DAY_W-1:0]    cur_len;

    // Loaded year, kept modulo 2^YEAR_BITS.
    assign load_year = YEAR_BITS'(i_in_data.load_year);

    // Year modulo 400 after a load.
    cds_mod400 #(
        .YEAR_BITS (YEAR_BITS)
    ) u_mod400 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_year  (load_year),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    // Single-day step of the held date.
    cds_day_step #(
        .YEAR_BITS (YEAR_BITS)
    ) u_day_step (
        .i_back  (r_back),
        .i_year  (r_year),
        .i_month (r_month),
        .i_day   (r_day),
        .i_mod   (r_mod),
        .o_year  (st_year),
        .o_month (st_month),
        .o_day   (st_day),
        .o_mod   (st_mod)
    );

    assign in_fire    = i_in_valid && o_in_ready;
    assign in_count   = COUNT_BITS'(i_in_data.count);
    assign o_in_ready = (r_state == cds_pkg::ST_IDLE);

    // Flags of the held date.
    assign cur_leap = cds_pkg::leap_of_mod(r_mod);
    assign cur_len  = cds_pkg::month_len(r_month, cur_leap);

    // Sequencer: next state, date update and output word.
    always_comb begin
        n_state     = r_state;
        n_year      = r_year;
        n_month     = r_month;
        n_day       = r_day;
        n_mod       = r_mod;
        n_remain    = r_remain;
        n_back      = r_back;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        mod_start   = 1'b0;
        unique case (r_state)
            cds_pkg::ST_IDLE: begin
                if (in_fire) begin
                    priority if (i_in_data.mode == cds_pkg::MODE_LOAD) begin
                        n_year    = load_year;
                        n_month   = i_in_data.load_month;
                        n_day     = i_in_data.load_day;
                        mod_start = 1'b1;
                        n_state   = cds_pkg::ST_LOAD;
                    end else if ((i_in_data.mode == cds_pkg::MODE_FWD ||
                                  i_in_data.mode == cds_pkg::MODE_BWD) &&
                                 in_count != '0) begin
                        n_remain = in_count;
                        n_back   = (i_in_data.mode == cds_pkg::MODE_BWD);
                        n_state  = cds_pkg::ST_STEP;
                    end else begin
                        n_state = cds_pkg::ST_DONE;
                    end
                end
            end
            cds_pkg::ST_LOAD: begin
                if (mod_done) begin
                    n_mod   = mod_rem;
                    n_state = cds_pkg::ST_DONE;
                end
            end
            cds_pkg::ST_STEP: begin
                n_year   = st_year;
                n_month  = st_month;
                n_day    = st_day;
                n_mod    = st_mod;
                n_remain = r_remain - COUNT_BITS'(1);
                if (r_remain == COUNT_BITS'(1)) begin
                    n_state = cds_pkg::ST_DONE;
                end
            end
            cds_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid         = 1'b1;
                    n_out_data.cur_year  = cds_pkg::PORT_YEAR_W'(r_year);
                    n_out_data.cur_month = r_month;
                    n_out_data.cur_day   = r_day;
                    n_out_data.is_leap   = cur_leap;
                    n_out_data.is_valid  = (r_month >= cds_pkg::MON_JAN) &&
                                           (r_month <= cds_pkg::MON_DEC) &&
                                           (r_day >= cds_pkg::DAY_FIRST) &&
                                           (r_day <= cur_len);
                    n_state             = cds_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cds_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and date registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cds_pkg::ST_IDLE;
            r_year      <= YEAR_BITS'(cds_pkg::RESET_YEAR);
            r_month     <= cds_pkg::MON_JAN;
            r_day       <= cds_pkg::DAY_FIRST;
            r_mod       <= cds_pkg::MOD_W'(cds_pkg::RESET_YEAR % cds_pkg::MOD_BASE);
            r_remain    <= '0;
            r_back      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_year      <= n_year;
            r_month     <= n_month;
            r_day       <= n_day;
            r_mod       <= n_mod;
            r_remain    <= n_remain;
            r_back      <= n_back;
            r_out_valid <= n_out_valid;
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[rtl/core/cds_mod400.sv]
module cds_mod400 #(
    parameter int unsigned YEAR_BITS = cds_pkg::DEF_YEAR_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [YEAR_BITS-1:0]        i_year,
    output logic                        o_done,
    output logic [cds_pkg::MOD_W-1:0]   o_rem
);

    // 400 is 16 times 25: the low four year bits pass straight through and
    // only the upper bits are reduced modulo 25.
    localparam int unsigned LOW_W  = 4;
    localparam int unsigned ODD    = cds_pkg::MOD_BASE >> LOW_W;
    localparam int unsigned ODD_W  = cds_pkg::MOD_W - LOW_W;
    localparam int unsigned HI_W   = YEAR_BITS - LOW_W;
    localparam int unsigned SHIFT  = HI_W + ODD_W;
    localparam int unsigned RCP_W  = HI_W + 1;
    localparam int unsigned PROD_W = HI_W + RCP_W;
    localparam int unsigned QUOT_W = PROD_W - SHIFT;

    // Reciprocal of 25 rounded up; its rounding error is small enough that
    // the shifted product is the exact quotient for every HI_W-bit value.
    localparam logic [63:0] RECIP = ((64'd1 << SHIFT) + 64'(ODD) - 64'd1) / 64'(ODD);

    logic                      r_busy;
    logic                      r_done;
    logic [HI_W-1:0]           r_hi;
    logic [LOW_W-1:0]          r_low;
    logic [QUOT_W-1:0]         r_quot;
    logic [cds_pkg::MOD_W-1:0] r_rem;
    logic [PROD_W-1:0]         prod;
    logic [HI_W-1:0]           odd_rem;

    // First step: quotient of the upper year bits by 25.
    assign prod = PROD_W'(i_year[YEAR_BITS-1:LOW_W]) * PROD_W'(RECIP[RCP_W-1:0]);

    // Second step: what is left of the upper bits after taking out 25 times
    // the quotient, always below 25.
    assign odd_rem = r_hi - HI_W'(r_quot) * HI_W'(ODD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hi   <= i_year[YEAR_BITS-1:LOW_W];
            r_low  <= i_year[LOW_W-1:0];
            r_quot <= prod[PROD_W-1:SHIFT];
        end
        if (r_busy) begin
            r_rem <= {odd_rem[ODD_W-1:0], r_low};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[rtl/core/cds_day_step.sv]
module cds_day_step #(
    parameter int unsigned YEAR_BITS = cds_pkg::DEF_YEAR_BITS
) (
    input  logic                          i_back,
    input  logic [YEAR_BITS-1:0]          i_year,
    input  logic [cds_pkg::MONTH_W-1:0]   i_month,
    input  logic [cds_pkg::DAY_W-1:0]     i_day,
    input  logic [cds_pkg::MOD_W-1:0]     i_mod,
    output logic [YEAR_BITS-1:0]          o_year,
    output logic [cds_pkg::MONTH_W-1:0]   o_month,
    output logic [cds_pkg::DAY_W-1:0]     o_day,
    output logic [cds_pkg::MOD_W-1:0]     o_mod
);

    // Residue of the largest year, reached when the year wraps below zero.
    localparam logic [63:0] YEAR_TOP = (64'd1 << YEAR_BITS) - 64'd1;
    localparam int unsigned WRAP_MOD = int'(YEAR_TOP % 64'd400);
    localparam int unsigned MOD_LAST = cds_pkg::MOD_BASE - 1;

    logic                        leap;
    logic [cds_pkg::MONTH_W-1:0] prev_month;

    assign leap       = cds_pkg::leap_of_mod(i_mod);
    assign prev_month = i_month - cds_pkg::MONTH_W'(1);

    // One calendar day forward or backward, with year rollover.
    always_comb begin
        o_year  = i_year;
        o_month = i_month;
        o_day   = i_day;
        o_mod   = i_mod;
        if (!i_back) begin
            if (i_day == cds_pkg::LEN_LONG && i_month == cds_pkg::MON_DEC) begin
                o_day   = cds_pkg::DAY_FIRST;
                o_month = cds_pkg::MON_JAN;
                o_year  = i_year + YEAR_BITS'(1);
                if (i_year == '1 || i_mod == cds_pkg::MOD_W'(MOD_LAST)) begin
                    o_mod = '0;
                end else begin
                    o_mod = i_mod + cds_pkg::MOD_W'(1);
                end
            end else if (i_day == cds_pkg::month_len(i_month, leap)) begin
                o_month = i_month + cds_pkg::MONTH_W'(1);
                o_day   = cds_pkg::DAY_FIRST;
            end else begin
                o_day = i_day + cds_pkg::DAY_W'(1);
            end
        end else begin
            if (i_day == cds_pkg::DAY_FIRST && i_month == cds_pkg::MON_JAN) begin
                o_day   = cds_pkg::LEN_LONG;
                o_month = cds_pkg::MON_DEC;
                o_year  = i_year - YEAR_BITS'(1);
                if (i_year == '0) begin
                    o_mod = cds_pkg::MOD_W'(WRAP_MOD);
                end else if (i_mod == '0) begin
                    o_mod = cds_pkg::MOD_W'(MOD_LAST);
                end else begin
                    o_mod = i_mod - cds_pkg::MOD_W'(1);
                end
            end else if (i_day == cds_pkg::DAY_FIRST) begin
                o_month = prev_month;
                o_day   = cds_pkg::month_len(prev_month, leap);
            end else begin
                o_day = i_day - cds_pkg::DAY_W'(1);
            end
        end
    end

endmodule

[rtl/core/cds_checker.sv]
module cds_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input cds_pkg::t_in_word  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input cds_pkg::t_out_word o_out_data
);

    // A word waiting on the output holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output word changed or dropped while stalled");

    // Only one input word is in flight.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("unit ready again right after accepting a word");

    // A valid date always has a real month and a nonzero day.
    a_valid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.is_valid |->
            o_out_data.cur_month >= cds_pkg::MON_JAN &&
            o_out_data.cur_month <= cds_pkg::MON_DEC &&
            o_out_data.cur_day != '0)
        else $error("valid flag on an impossible date");

    // A valid 29 February only exists in a leap year.
    a_leap_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.is_valid &&
        o_out_data.cur_month == cds_pkg::MON_FEB &&
        o_out_data.cur_day == cds_pkg::LEN_LEAP |-> o_out_data.is_leap)
        else $error("29 February reported valid outside a leap year");

endmodule

bind calendar_date_stepper_unit cds_checker u_cds_checker (.*);

[tb/sv/tb_calendar_date_stepper_unit.sv]
module tb_calendar_date_stepper_unit;

    localparam int unsigned RANDOM_WORDS = 1430;
    localparam int unsigned IDLE_LIMIT   = 300000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned PAUSE_EVERY  = 300;

    // One row of the directed table; want is used only where known is set.
    typedef struct {
        cds_pkg::t_in_word  word;
        bit                 known;
        cds_pkg::t_out_word want;
    } t_table_row;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    cds_pkg::t_in_word  in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    cds_pkg::t_out_word out_data;

    // Predicted date held by the testbench.
    logic [15:0]                 date_year;
    logic [cds_pkg::MONTH_W-1:0] date_month;
    logic [cds_pkg::DAY_W-1:0]   date_day;

    cds_pkg::t_out_word expected_dates[$];
    t_table_row         directed_table[$];

    int unsigned mismatches = 0;
    int unsigned checked = 0;
    int unsigned idle_cycles = 0;
    int unsigned burst_left = 0;
    int unsigned n_load = 0;
    int unsigned n_fwd = 0;
    int unsigned n_bwd = 0;
    int unsigned n_none = 0;
    int unsigned n_invalid = 0;
    longint unsigned days_stepped = 0;
    int unsigned longest_step = 0;

    calendar_date_stepper_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    // Gregorian leap rule on the full year value.
    function automatic logic leap_year(input logic [15:0] y);
        int unsigned v;
        v = 32'(y);
        return ((v % 4) == 0 && (v % 100) != 0) || (v % 400) == 0;
    endfunction

    // Month length; months outside January to December have no days.
    function automatic logic [cds_pkg::DAY_W-1:0] days_in_month(
        input logic [cds_pkg::MONTH_W-1:0] m,
        input logic [15:0] y
    );
        case (m)
            cds_pkg::MON_JAN, cds_pkg::MON_MAR, cds_pkg::MON_MAY, cds_pkg::MON_JUL,
            cds_pkg::MON_AUG, cds_pkg::MON_OCT, cds_pkg::MON_DEC:
                return cds_pkg::LEN_LONG;
            cds_pkg::MON_APR, cds_pkg::MON_JUN, cds_pkg::MON_SEP, cds_pkg::MON_NOV:
                return cds_pkg::LEN_SHORT;
            cds_pkg::MON_FEB:
                return leap_year(y) ? cds_pkg::LEN_LEAP : cds_pkg::LEN_FEB;
            default:
                return cds_pkg::LEN_NONE;
        endcase
    endfunction

    // One day forward; month and day wrap at their field widths.
    task automatic advance_one_day();
        if (date_day == cds_pkg::LEN_LONG && date_month == cds_pkg::MON_DEC) begin
            date_day = cds_pkg::DAY_FIRST;
            date_month = cds_pkg::MON_JAN;
            date_year = date_year + 16'd1;
        end else if (date_day == days_in_month(date_month, date_year)) begin
            date_month = date_month + 4'd1;
            date_day = cds_pkg::DAY_FIRST;
        end else begin
            date_day = date_day + 5'd1;
        end
    endtask

    // One day backward; going into a month lands on its last day.
    task automatic retreat_one_day();
        if (date_day == cds_pkg::DAY_FIRST && date_month == cds_pkg::MON_JAN) begin
            date_day = cds_pkg::LEN_LONG;
            date_month = cds_pkg::MON_DEC;
            date_year = date_year - 16'd1;
        end else if (date_day == cds_pkg::DAY_FIRST) begin
            date_month = date_month - 4'd1;
            date_day = days_in_month(date_month, date_year);
        end else begin
            date_day = date_day - 5'd1;
        end
    endtask

    // Apply one input word to the predicted date and return the result word.
    task automatic apply_word(input cds_pkg::t_in_word w, output cds_pkg::t_out_word r);
        case (w.mode)
            cds_pkg::MODE_LOAD: begin
                date_year = w.load_year;
                date_month = w.load_month;
                date_day = w.load_day;
            end
            cds_pkg::MODE_FWD: begin
                for (int k = 0; k < int'(w.count); k++) advance_one_day();
            end
            cds_pkg::MODE_BWD: begin
                for (int k = 0; k < int'(w.count); k++) retreat_one_day();
            end
            default: begin
            end
        endcase
        r.cur_year = date_year;
        r.cur_month = date_month;
        r.cur_day = date_day;
        r.is_leap = leap_year(date_year);
        r.is_valid = date_month >= cds_pkg::MON_JAN && date_month <= cds_pkg::MON_DEC &&
                     date_day >= cds_pkg::DAY_FIRST &&
                     date_day <= days_in_month(date_month, date_year);
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Directed table rows: the first form is checked against the predictor.
    task automatic add_row(input logic [1:0] mode, input logic [15:0] count,
                           input logic [15:0] yr, input logic [3:0] mon,
                           input logic [4:0] day);
        t_table_row row;
        row.word = '{mode: mode, count: count, load_year: yr, load_month: mon,
                     load_day: day};
        row.known = 1'b0;
        row.want = '0;
        directed_table.push_back(row);
    endtask

    task automatic add_known_row(input logic [1:0] mode, input logic [15:0] count,
                                 input logic [15:0] yr, input logic [3:0] mon,
                                 input logic [4:0] day, input logic [15:0] e_yr,
                                 input logic [3:0] e_mon, input logic [4:0] e_day,
                                 input logic e_leap, input logic e_valid);
        add_row(mode, count, yr, mon, day);
        directed_table[$].known = 1'b1;
        directed_table[$].want = '{cur_year: e_yr, cur_month: e_mon, cur_day: e_day,
                                   is_leap: e_leap, is_valid: e_valid};
    endtask

    // Random word: mostly valid loads and short steps, a few long steps and unused-mode words.
    function automatic cds_pkg::t_in_word random_word();
        cds_pkg::t_in_word w;
        int unsigned pick;
        logic [4:0] len;
        w.count = 16'($urandom_range(0, 65535));
        w.load_year = 16'($urandom_range(0, 65535));
        w.load_month = 4'($urandom_range(0, 15));
        w.load_day = 5'($urandom_range(0, 31));
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            w.mode = cds_pkg::MODE_LOAD;
            pick = $urandom_range(0, 9);
            if (pick < 3)
                w.load_year = 16'(100 * $urandom_range(0, 655) + $urandom_range(0, 4));
            else if (pick < 5)
                w.load_year = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3))
                                                         : 16'(65535 - $urandom_range(0, 3));
            if ($urandom_range(0, 99) < 85)
                w.load_month = 4'($urandom_range(cds_pkg::MON_JAN, cds_pkg::MON_DEC));
            len = days_in_month(w.load_month, w.load_year);
            pick = $urandom_range(0, 99);
            if (len != cds_pkg::LEN_NONE && pick < 60)
                w.load_day = 5'($urandom_range(1, len));
            else if (len != cds_pkg::LEN_NONE && pick < 85)
                w.load_day = ($urandom_range(0, 1) == 0) ? len : cds_pkg::DAY_FIRST;
        end else if (pick < 95) begin
            w.mode = (pick < 60) ? cds_pkg::MODE_FWD : cds_pkg::MODE_BWD;
            pick = $urandom_range(0, 399);
            if (pick == 0)
                w.count = 16'($urandom_range(0, 65535));
            else if (pick < 100)
                w.count = 16'($urandom_range(41, 800));
            else
                w.count = 16'($urandom_range(0, 40));
        end else begin
            w.mode = cds_pkg::MODE_NONE;
        end
        return w;
    endfunction

    // Send one word in bursts with random gaps; the expectation is queued on acceptance.
    task automatic drive_word(input cds_pkg::t_in_word w, input bit known,
                              input cds_pkg::t_out_word want);
        cds_pkg::t_out_word predicted;
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        apply_word(w, predicted);
        expected_dates.push_back(known ? want : predicted);
        case (w.mode)
            cds_pkg::MODE_LOAD: n_load++;
            cds_pkg::MODE_FWD:  n_fwd++;
            cds_pkg::MODE_BWD:  n_bwd++;
            default:            n_none++;
        endcase
        if (w.mode == cds_pkg::MODE_FWD || w.mode == cds_pkg::MODE_BWD) begin
            days_stepped += 64'(w.count);
            if (32'(w.count) > longest_step) longest_step = 32'(w.count);
        end
        @(negedge clk);
    endtask

    // Hold the sender off until every queued result word has come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_dates.size() != 0) @(negedge clk);
        burst_left = 0;
    endtask

    // Receiver stalls in phases: always ready, half ready, mostly stalled.
    initial begin
        int unsigned kind;
        int unsigned span;
        forever begin
            kind = $urandom_range(0, 2);
            span = $urandom_range(20, 300);
            repeat (span) begin
                @(negedge clk);
                case (kind)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Check each accepted result word against the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_dates.size() == 0) begin
                report_mismatch($sformatf("result word %h with nothing expected", out_data));
            end else begin
                if (out_data.cur_year !== expected_dates[0].cur_year)
                    report_mismatch($sformatf("word %0d cur_year got %0d, expected %0d",
                        checked, out_data.cur_year, expected_dates[0].cur_year));
                if (out_data.cur_month !== expected_dates[0].cur_month)
                    report_mismatch($sformatf("word %0d cur_month got %0d, expected %0d",
                        checked, out_data.cur_month, expected_dates[0].cur_month));
                if (out_data.cur_day !== expected_dates[0].cur_day)
                    report_mismatch($sformatf("word %0d cur_day got %0d, expected %0d",
                        checked, out_data.cur_day, expected_dates[0].cur_day));
                if (out_data.is_leap !== expected_dates[0].is_leap)
                    report_mismatch($sformatf("word %0d is_leap got %b, expected %b",
                        checked, out_data.is_leap, expected_dates[0].is_leap));
                if (out_data.is_valid !== expected_dates[0].is_valid)
                    report_mismatch($sformatf("word %0d is_valid got %b, expected %b",
                        checked, out_data.is_valid, expected_dates[0].is_valid));
                if (!expected_dates[0].is_valid) n_invalid++;
                void'(expected_dates.pop_front());
            end
            checked++;
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("ERROR: no handshake for %0d cycles", IDLE_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        cds_pkg::t_out_word none_word;
        none_word = '0;
        date_year = 16'(cds_pkg::RESET_YEAR);
        date_month = cds_pkg::MON_JAN;
        date_day = cds_pkg::DAY_FIRST;

        // Directed table: reset value, leap rules, year wrap and invalid dates.
        add_known_row(cds_pkg::MODE_NONE, 16'd0, 16'd0, 4'd0, 5'd0,
                      16'd2000, cds_pkg::MON_JAN, 5'd1, 1'b1, 1'b1);
        add_known_row(cds_pkg::MODE_FWD, 16'd0, 16'd0, 4'd0, 5'd0,
                      16'd2000, cds_pkg::MON_JAN, 5'd1, 1'b1, 1'b1);
        add_known_row(cds_pkg::MODE_LOAD, 16'd0, 16'd2023, cds_pkg::MON_DEC, 5'd31,
                      16'd2023, cds_pkg::MON_DEC, 5'd31, 1'b0, 1'b1);
        add_row(cds_pkg::MODE_FWD, 16'd1, 16'd0, 4'd0, 5'd0);
        add_row(cds_pkg::MODE_BWD, 16'd1, 16'd0, 4'd0, 5'd0);
        add_known_row(cds_pkg::MODE_LOAD, 16'd0, 16'd2024, cds_pkg::MON_FEB, 5'd28,
                      16'd2024, cds_pkg::MON_FEB, 5'd28, 1'b1, 1'b1);
        add_row(cds_pkg::MODE_FWD, 16'd1, 16'd0, 4'd0, 5'd0);
        add_row(cds_pkg::MODE_FWD, 16'd1, 16'd0, 4'd0, 5'd0);
        add_known_row(cds_pkg::MODE_LOAD, 16'd0, 16'd1900, cds_pkg::MON_FEB, 5'd28,
                      16'd1900, cds_pkg::MON_FEB, 5'd28, 1'b0, 1'b1);
        add_row(cds_pkg::MODE_FWD, 16'd1, 16'd0, 4'd0, 5'd0);
        add_known_row(cds_pkg::MODE_LOAD, 16'd0, 16'd2000, cds_pkg::MON_MAR, 5'd1,
                      16'd2000, cds_pkg::MON_MAR, 5'd1, 1'b1, 1'b1);
        add_row(cds_pkg::MODE_BWD, 16'd1, 16'd0, 4'd0, 5'd0);
        add_known_row(cds_pkg::MODE_LOAD, 16'd0, 16'd65535, cds_pkg::MON_DEC, 5'd31,
                      16'd65535, cds_pkg::MON_DEC, 5'd31, 1'b0, 1'b1);
        add_row(cds_pkg::MODE_FWD, 16'd1, 16'd0, 4'd0, 5'd0);
        add_row(cds_pkg::MODE_BWD, 16'd1, 16'd0, 4'd0, 5'd0);
        add_known_row(cds_pkg::MODE_LOAD, 16'd0, 16'd12345, 4'd0, 5'd0,
                      16'd12345, 4'd0, 5'd0, 1'b0, 1'b0);
        add_row(cds_pkg::MODE_FWD, 16'd1, 16'd0, 4'd0, 5'd0);
        add_known_row(cds_pkg::MODE_LOAD, 16'd0, 16'd100, 4'd15, 5'd31,
                      16'd100, 4'd15, 5'd31, 1'b0, 1'b0);
        add_row(cds_pkg::MODE_FWD, 16'd1, 16'd0, 4'd0, 5'd0);
        add_known_row(cds_pkg::MODE_LOAD, 16'd0, 16'd2000, 4'd0, 5'd1,
                      16'd2000, 4'd0, 5'd1, 1'b1, 1'b0);
        add_row(cds_pkg::MODE_BWD, 16'd1, 16'd0, 4'd0, 5'd0);
        add_known_row(cds_pkg::MODE_LOAD, 16'd0, 16'd2001, cds_pkg::MON_APR, 5'd31,
                      16'd2001, cds_pkg::MON_APR, 5'd31, 1'b0, 1'b0);
        add_row(cds_pkg::MODE_FWD, 16'hFFFF, 16'd0, 4'd0, 5'd0);
        add_row(cds_pkg::MODE_BWD, 16'hFFFF, 16'd0, 4'd0, 5'd0);
        add_row(cds_pkg::MODE_NONE, 16'hFFFF, 16'hFFFF, 4'hF, 5'h1F);

        // Synchronous reset, released on a falling edge.
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_table[i])
            drive_word(directed_table[i].word, directed_table[i].known,
                       directed_table[i].want);
        wait_for_results();

        for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
            if (n != 0 && (n % PAUSE_EVERY) == 0) wait_for_results();
            drive_word(random_word(), 1'b0, none_word);
        end

        // Drain: wait for the last results, then watch for stray words.
        in_valid <= 1'b0;
        while (expected_dates.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_dates.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived", expected_dates.size()));

        $display("Checked %0d result words: %0d loads, %0d forward, %0d backward, %0d unused.",
                 checked, n_load, n_fwd, n_bwd, n_none);
        $display("Stepped %0d days in all, longest step %0d days, %0d invalid dates seen.",
                 days_stepped, longest_step, n_invalid);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/cds_pkg.sv
rtl/core/cds_mod400.sv
rtl/core/cds_day_step.sv
rtl/core/calendar_date_stepper_unit.sv
rtl/core/cds_checker.sv
tb/sv/tb_calendar_date_stepper_unit.sv
